/* rtl/dfrw_pkg.sv */
// shared types and constants for the delayed feedback random walk step
package dfrw_pkg;

    // field widths
    localparam int RAND_W  = 16;
    localparam int WALK_W  = 7;
    localparam int DELAY_W = 9;
    localparam int RANGE_W = 6;
    localparam int GAIN_W  = 20;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 20;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_DELAY_A    = 3'd0;
    localparam logic [CIDX_W-1:0] REG_DELAY_B    = 3'd1;
    localparam logic [CIDX_W-1:0] REG_HALF_RANGE = 3'd2;
    localparam logic [CIDX_W-1:0] REG_FLAT_ZONE  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_GAIN       = 3'd4;

    // reset values
    localparam int                 RST_DELAY_A    = 200;
    localparam int                 RST_DELAY_B    = 0;
    localparam logic [RANGE_W-1:0] RST_HALF_RANGE = 6'd50;
    localparam logic [RANGE_W-1:0] RST_FLAT_ZONE  = 6'd20;
    localparam logic [GAIN_W-1:0]  RST_GAIN       = 20'd276825;

    typedef logic signed [WALK_W-1:0] t_walk;

    // feedback shaping settings seen by the step logic
    typedef struct packed {
        logic [RANGE_W-1:0] half_range;
        logic [RANGE_W-1:0] flat_zone;
        logic [GAIN_W-1:0]  gain;
    } t_shape_cfg;

endpackage

/* rtl/dfrw_step.sv */
// combinational step decision: feedback threshold, compare and saturating step
module dfrw_step (
    input  logic [dfrw_pkg::RAND_W-1:0] i_rand,
    input  dfrw_pkg::t_walk             i_cur,
    input  dfrw_pkg::t_walk             i_xa,
    input  dfrw_pkg::t_walk             i_xb,
    input  dfrw_pkg::t_shape_cfg        i_cfg,
    output dfrw_pkg::t_walk             o_next
);

    logic signed [8:0]  h_s;
    logic signed [8:0]  d_s;
    logic signed [8:0]  span;
    logic signed [8:0]  h_m_xa;
    logic signed [8:0]  h_p_xb;
    logic signed [8:0]  min_a;
    logic signed [8:0]  min_b;
    logic signed [8:0]  diff;
    logic        [29:0] prod;
    logic signed [22:0] thr;
    logic signed [22:0] rand_s;
    logic               step_up;
    logic signed [7:0]  cur8;
    logic signed [7:0]  inc8;
    logic signed [7:0]  dec8;
    logic signed [7:0]  h8;
    logic signed [7:0]  next8;

    // feedback difference from the two delayed values
    always_comb begin
        h_s    = $signed({3'b000, i_cfg.half_range});
        d_s    = $signed({3'b000, i_cfg.flat_zone});
        span   = h_s - d_s;
        h_m_xa = h_s - $signed({{2{i_xa[6]}}, i_xa});
        h_p_xb = h_s + $signed({{2{i_xb[6]}}, i_xb});
        min_a  = (span < h_m_xa) ? span : h_m_xa;
        min_b  = (span < h_p_xb) ? span : h_p_xb;
        diff   = min_a - min_b;
    end

    // scaled threshold, floor of the product over 256
    always_comb begin
        prod    = {{21{diff[8]}}, diff} * {10'd0, i_cfg.gain};
        thr     = $signed({prod[29], prod[29:8]}) + 23'sd32768;
        rand_s  = $signed({7'd0, i_rand});
        step_up = (rand_s < thr);
    end

    // saturating step
    always_comb begin
        cur8 = $signed({i_cur[6], i_cur});
        inc8 = cur8 + 8'sd1;
        dec8 = cur8 - 8'sd1;
        h8   = $signed({2'b00, i_cfg.half_range});
        if (step_up) begin
            next8 = (inc8 > h8) ? h8 : inc8;
        end else begin
            next8 = (dec8 < -h8) ? -h8 : dec8;
        end
        o_next = next8[6:0];
    end

endmodule

/* rtl/delayed_feedback_random_walk_step.sv */
// top level of the delayed feedback random walk step: history memory and handshakes
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------------
//  in      | to block  | i_in_valid / o_in_ready     | i_rand_fraction [15:0]
//  out     | from blk  | o_out_valid / i_out_ready   | o_walk_value [6:0] signed
//  cfg     | to block  | i_cfg_valid / o_cfg_ready   | i_cfg_index [2:0], i_cfg_data
//
// one word per cycle sustained while the output is taken: the input register stage also
// takes the registered history reads, the output register holds the new walk value.
// the history needs no clearing pass: a fill count marks entries not yet written,
// which read as zero (entry 0 as one). reset is synchronous and active low.
// a stall on the output holds both stages; a word then enters only an empty input stage.
module delayed_feedback_random_walk_step #(
    parameter int HISTORY_DEPTH = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [dfrw_pkg::RAND_W-1:0]    i_rand_fraction,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [dfrw_pkg::WALK_W-1:0] o_walk_value,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dfrw_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [dfrw_pkg::CDAT_W-1:0]    i_cfg_data
);

    localparam int AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int MOD_D = (HISTORY_DEPTH < 512) ? HISTORY_DEPTH : 512;
    localparam int RECIP = (1 << 20) / MOD_D;
    localparam logic [AW-1:0] LAST_PTR   = AW'(HISTORY_DEPTH - 1);
    localparam logic [AW-1:0] RST_BACK_A = AW'(dfrw_pkg::RST_DELAY_A % HISTORY_DEPTH);
    localparam logic [AW-1:0] RST_BACK_B = AW'(dfrw_pkg::RST_DELAY_B % HISTORY_DEPTH);

    // delay reduced modulo the depth: reciprocal multiply, one correcting subtract
    function automatic logic [AW-1:0] f_wrap_delay(input logic [dfrw_pkg::DELAY_W-1:0] delay);
        logic [28:0] prod;
        logic [8:0]  quo;
        logic [18:0] qd;
        logic [18:0] rem_w;
        logic [9:0]  rem;
        prod  = 29'(delay) * 29'(RECIP);
        quo   = prod[28:20];
        qd    = 19'(quo) * 19'(MOD_D);
        rem_w = 19'(delay) - qd;
        rem   = rem_w[9:0];
        if (rem >= 10'(MOD_D)) begin
            rem = rem - 10'(MOD_D);
        end
        return AW'(rem);
    endfunction

    function automatic logic [AW-1:0] f_inc_ptr(input logic [AW-1:0] ptr);
        return (ptr == LAST_PTR) ? '0 : ptr + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_back_addr(input logic [AW-1:0] ptr,
                                                  input logic [AW-1:0] back);
        logic [AW:0] wrapped;
        wrapped = {1'b0, ptr} + (AW+1)'(HISTORY_DEPTH) - {1'b0, back};
        return (ptr >= back) ? ptr - back : wrapped[AW-1:0];
    endfunction

    // configuration
    logic [AW-1:0]        r_back_a;
    logic [AW-1:0]        r_back_b;
    dfrw_pkg::t_shape_cfg r_cfg;

    // pointers and fill count
    logic [AW-1:0] r_acc_ptr;
    logic [CW-1:0] r_fill;

    // input register stage
    logic                        r_s1_vld;
    logic [dfrw_pkg::RAND_W-1:0] r_s1_rand;
    logic [AW-1:0]               r_s1_wr_ptr;
    logic                        r_s1_fwd_a;
    logic                        r_s1_fwd_b;
    logic                        r_s1_ok_a;
    logic                        r_s1_ok_b;
    logic                        r_s1_zero_a;
    logic                        r_s1_zero_b;
    dfrw_pkg::t_walk             r_rd_a;
    dfrw_pkg::t_walk             r_rd_b;

    // newest value and output register
    dfrw_pkg::t_walk r_cur;
    logic            r_out_vld;
    dfrw_pkg::t_walk r_out_walk;

    dfrw_pkg::t_walk history [HISTORY_DEPTH];

    logic            in_acc;
    logic            s1_adv;
    logic [AW-1:0]   addr_a;
    logic [AW-1:0]   addr_b;
    dfrw_pkg::t_walk xa;
    dfrw_pkg::t_walk xb;
    dfrw_pkg::t_walk n_walk;

    // handshakes
    assign s1_adv      = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_s1_vld || s1_adv;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_walk_value = r_out_walk;

    assign addr_a = f_back_addr(r_acc_ptr, r_back_a);
    assign addr_b = f_back_addr(r_acc_ptr, r_back_b);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back_a         <= RST_BACK_A;
            r_back_b         <= RST_BACK_B;
            r_cfg.half_range <= dfrw_pkg::RST_HALF_RANGE;
            r_cfg.flat_zone  <= dfrw_pkg::RST_FLAT_ZONE;
            r_cfg.gain       <= dfrw_pkg::RST_GAIN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dfrw_pkg::REG_DELAY_A:
                    r_back_a <= f_wrap_delay(i_cfg_data[dfrw_pkg::DELAY_W-1:0]);
                dfrw_pkg::REG_DELAY_B:
                    r_back_b <= f_wrap_delay(i_cfg_data[dfrw_pkg::DELAY_W-1:0]);
                dfrw_pkg::REG_HALF_RANGE:
                    r_cfg.half_range <= i_cfg_data[dfrw_pkg::RANGE_W-1:0];
                dfrw_pkg::REG_FLAT_ZONE:
                    r_cfg.flat_zone <= i_cfg_data[dfrw_pkg::RANGE_W-1:0];
                dfrw_pkg::REG_GAIN:
                    r_cfg.gain <= i_cfg_data[dfrw_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // control state of the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_ptr <= '0;
            r_fill    <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cur     <= 7'sd1;
        end else begin
            if (in_acc) begin
                r_acc_ptr <= f_inc_ptr(r_acc_ptr);
                if (r_fill != CW'(HISTORY_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
                r_cur     <= n_walk;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // input stage payload and read qualifiers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_rand   <= i_rand_fraction;
            r_s1_wr_ptr <= f_inc_ptr(r_acc_ptr);
            r_s1_fwd_a  <= (r_back_a == '0);
            r_s1_fwd_b  <= (r_back_b == '0);
            r_s1_ok_a   <= (CW'(r_back_a) < r_fill);
            r_s1_ok_b   <= (CW'(r_back_b) < r_fill);
            r_s1_zero_a <= (addr_a == '0);
            r_s1_zero_b <= (addr_b == '0);
        end
    end

    // history memory, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            history[r_s1_wr_ptr] <= n_walk;
        end
        if (in_acc) begin
            r_rd_a <= history[addr_a];
            r_rd_b <= history[addr_b];
        end
    end

    // delayed values: newest from its register, unwritten entries at their reset value
    always_comb begin
        if (r_s1_fwd_a) begin
            xa = r_cur;
        end else if (r_s1_ok_a) begin
            xa = r_rd_a;
        end else begin
            xa = r_s1_zero_a ? 7'sd1 : 7'sd0;
        end
        if (r_s1_fwd_b) begin
            xb = r_cur;
        end else if (r_s1_ok_b) begin
            xb = r_rd_b;
        end else begin
            xb = r_s1_zero_b ? 7'sd1 : 7'sd0;
        end
    end

    dfrw_step u_step (
        .i_rand (r_s1_rand),
        .i_cur  (r_cur),
        .i_xa   (xa),
        .i_xb   (xb),
        .i_cfg  (r_cfg),
        .o_next (n_walk)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_walk <= n_walk;
        end
    end

endmodule

/* tb/sv/walk_checker.sv */
// walk checker: predicts each walk word from the accepted random words and compares
`timescale 1ns / 100ps

module walk_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [dfrw_pkg::RAND_W-1:0]         i_rand_fraction,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [dfrw_pkg::WALK_W-1:0]  i_walk_value,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [dfrw_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [dfrw_pkg::CDAT_W-1:0]         i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending
);

    // history depth is 2**DELAY_W, so pointer arithmetic wraps on its own
    localparam int PW    = dfrw_pkg::DELAY_W;
    localparam int DEPTH = 1 << PW;

    // own copy of the settings
    logic [PW-1:0]                  delay_a;
    logic [PW-1:0]                  delay_b;
    logic [dfrw_pkg::RANGE_W-1:0]   half_range;
    logic [dfrw_pkg::RANGE_W-1:0]   flat_zone;
    logic [dfrw_pkg::GAIN_W-1:0]    gain;

    // own copy of the walk history
    dfrw_pkg::t_walk    history [DEPTH];
    logic [PW-1:0]      head;
    dfrw_pkg::t_walk    walk_due [$];

    // next walk value for one random fraction
    function automatic dfrw_pkg::t_walk step_walk(
        input logic [dfrw_pkg::RAND_W-1:0] fraction);
        int     h;
        int     span;
        int     xa;
        int     xb;
        int     cur;
        int     diff;
        int     nxt;
        longint thr;
        h    = int'(half_range);
        span = h - int'(flat_zone);
        xa   = int'(history[PW'(head - delay_a)]);
        xb   = int'(history[PW'(head - delay_b)]);
        cur  = int'(history[head]);
        diff = ((span < h - xa) ? span : h - xa) - ((span < h + xb) ? span : h + xb);
        // floor of the scaled feedback, no saturation of the threshold
        thr  = 64'sd32768 + ((longint'(diff) * longint'(gain)) >>> 8);
        if (longint'(fraction) < thr) begin
            nxt = cur + 1;
            if (nxt > h) nxt = h;
        end else begin
            nxt = cur - 1;
            if (nxt < -h) nxt = -h;
        end
        return dfrw_pkg::t_walk'(nxt);
    endfunction

    // watch the three channels at each rising edge
    always @(posedge i_clk) begin : watch
        dfrw_pkg::t_walk want;
        dfrw_pkg::t_walk nxt;
        if (!i_rst_n) begin
            delay_a    = PW'(dfrw_pkg::RST_DELAY_A);
            delay_b    = PW'(dfrw_pkg::RST_DELAY_B);
            half_range = dfrw_pkg::RST_HALF_RANGE;
            flat_zone  = dfrw_pkg::RST_FLAT_ZONE;
            gain       = dfrw_pkg::RST_GAIN;
            for (int i = 0; i < DEPTH; i++) history[i] = '0;
            history[0] = dfrw_pkg::t_walk'(1);
            head       = '0;
            walk_due.delete();
            o_errors   = 0;
            o_pending  = 0;
        end else begin
            // register writes, unknown indexes ignored
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    dfrw_pkg::REG_DELAY_A:    delay_a    = i_cfg_data[PW-1:0];
                    dfrw_pkg::REG_DELAY_B:    delay_b    = i_cfg_data[PW-1:0];
                    dfrw_pkg::REG_HALF_RANGE:
                        half_range = i_cfg_data[dfrw_pkg::RANGE_W-1:0];
                    dfrw_pkg::REG_FLAT_ZONE:
                        flat_zone  = i_cfg_data[dfrw_pkg::RANGE_W-1:0];
                    dfrw_pkg::REG_GAIN:
                        gain       = i_cfg_data[dfrw_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
            // result word against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (walk_due.size() == 0) begin
                    $error("walk_value: word %0d arrived with nothing expected", i_walk_value);
                    o_errors = o_errors + 1;
                end else begin
                    want = walk_due.pop_front();
                    if (i_walk_value !== want) begin
                        $error("walk_value: expected %0d, got %0d", want, i_walk_value);
                        o_errors = o_errors + 1;
                    end
                end
            end
            // random word in: step the walk and remember the value
            if (i_in_valid && i_in_ready) begin
                nxt          = step_walk(i_rand_fraction);
                head         = head + 1'b1;
                history[head] = nxt;
                walk_due.push_back(nxt);
            end
            o_pending = walk_due.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
// testbench top: clock, reset, stimulus and verdict for the walk step
`timescale 1ns / 100ps

module testbench;

    localparam int RW          = dfrw_pkg::RAND_W;
    localparam int IW          = dfrw_pkg::CIDX_W;
    localparam int DW          = dfrw_pkg::CDAT_W;
    localparam int GAIN_MAX    = (1 << dfrw_pkg::GAIN_W) - 1;
    localparam int DELAY_MAX   = (1 << dfrw_pkg::DELAY_W) - 1;
    localparam int HOLD_CYCLES = 60;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic [RW-1:0]       rand_fraction = '0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    dfrw_pkg::t_walk     walk_value;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [IW-1:0]       cfg_index     = '0;
    logic [DW-1:0]       cfg_data      = '0;
    int                  errors;
    int                  pending;

    // idle rates in percent, and long receiver hold-offs asked and served
    int send_idle = 12;
    int recv_idle = 66;
    int hold_asks = 0;
    int hold_done = 0;

    always #5 clk = ~clk;

    delayed_feedback_random_walk_step dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_rand_fraction (rand_fraction),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_walk_value    (walk_value),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    walk_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_rand_fraction (rand_fraction),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_walk_value    (walk_value),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    // offer one random word, with random idle cycles ahead of it
    task automatic send_word(input logic [RW-1:0] fraction);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        rand_fraction <= fraction;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // one register write; the caller lowers the valid after a batch
    task automatic write_reg(input logic [IW-1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DW'(value);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic setup_all(input int da, input int db, input int h, input int d,
                             input int g);
        write_reg(dfrw_pkg::REG_DELAY_A, da);
        write_reg(dfrw_pkg::REG_DELAY_B, db);
        write_reg(dfrw_pkg::REG_HALF_RANGE, h);
        write_reg(dfrw_pkg::REG_FLAT_ZONE, d);
        write_reg(dfrw_pkg::REG_GAIN, g);
    endtask

    // stop sending and let every predicted word come out, plus pipeline slack
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(negedge clk);
    endtask

    // receiver: random back-pressure, or a long hold-off when asked
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_asks != hold_done) begin
                hold_done = hold_done + 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // watchdog
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        int h;
        int d;
        int g;
        int span;
        int da;
        int db;
        logic [RW-1:0] fraction;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: threshold edges around one half
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'd32767);
        send_word(16'd32768);
        send_word(16'd12345);
        wait_drained();

        // no feedback, widest range, delays at both ends: walk climbs
        setup_all(0, DELAY_MAX, 63, 0, 0);
        cfg_valid <= 1'b0;
        repeat (7) send_word(16'h0000);
        send_word(16'd32767);
        wait_drained();

        // range lowered under the walk: steps down by one, a step up clamps
        write_reg(dfrw_pkg::REG_HALF_RANGE, 3);
        cfg_valid <= 1'b0;
        repeat (3) send_word(16'hFFFF);
        send_word(16'h0000);
        repeat (2) send_word(16'hFFFF);
        wait_drained();

        // zero range: walk pinned at zero
        write_reg(dfrw_pkg::REG_HALF_RANGE, 0);
        cfg_valid <= 1'b0;
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h0000);
        wait_drained();

        // flat zone beyond the range with full gain, plus writes to unused indexes
        setup_all(DELAY_MAX, 0, 5, 62, GAIN_MAX);
        for (int k = 1; k <= 3; k++) write_reg(dfrw_pkg::REG_GAIN + IW'(k), $urandom);
        cfg_valid <= 1'b0;
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'd40000);
        send_word(16'd20000);
        wait_drained();

        // random part in three idle patterns
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin send_idle = 12; recv_idle = 66; end
                1: begin send_idle = 66; recv_idle = 12; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (int k = 0; k < 150; k++) begin
                // new settings every fifty words, mostly well formed
                if (k % 50 == 0) begin
                    wait_drained();
                    case ($urandom_range(7))
                        0: h = 1;
                        1: h = 63;
                        default: h = $urandom_range(63, 1);
                    endcase
                    if ($urandom_range(7) == 0) d = $urandom_range(62);
                    else d = $urandom_range(h - 1);
                    span = h - d;
                    if (span > 0 && $urandom_range(7) != 0) begin
                        // about 0.99 / (2 (h - d)) in q24, give or take ten percent
                        g = (8304722 / span) * int'($urandom_range(110, 90)) / 100;
                        if (g > GAIN_MAX) g = GAIN_MAX;
                    end else begin
                        g = $urandom_range(GAIN_MAX);
                    end
                    case ($urandom_range(5))
                        0: da = 0;
                        1: da = DELAY_MAX;
                        default: da = $urandom_range(DELAY_MAX);
                    endcase
                    case ($urandom_range(5))
                        0: db = 0;
                        1: db = DELAY_MAX;
                        default: db = $urandom_range(DELAY_MAX);
                    endcase
                    setup_all(da, db, h, d, g);
                    if ($urandom_range(3) == 0) begin
                        write_reg(dfrw_pkg::REG_GAIN + IW'($urandom_range(3, 1)), $urandom);
                    end
                    cfg_valid <= 1'b0;
                end
                // long receiver hold-off while words keep coming
                if (k == 25) hold_asks = hold_asks + 1;
                // sender pause until the block has emptied
                if (k == 100) wait_drained();
                case ($urandom_range(15))
                    0: fraction = '0;
                    1: fraction = '1;
                    default: fraction = RW'($urandom_range(65535));
                endcase
                send_word(fraction);
            end
        end

        // let the last words out, with a limit
        in_valid <= 1'b0;
        for (int n = 0; n < 5000 && pending != 0; n++) @(negedge clk);
        repeat (10) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
